// ===== rtl/core/fppt_pkg.sv =====
// Shared types and codes of the fixed-priority periodic task picker.
package fppt_pkg;

    localparam int IDENT_W = 16;
    localparam int PRI_W   = 8;
    localparam int PER_W   = 16;
    localparam int REL_W   = 32;
    localparam int TICK_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_TICK_LIMIT = 1'b0;

    localparam logic [DATA_W-1:0] TICK_LIMIT_RESET = 32'hFFFF_FFFF;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_LOADED = 3'd0,
        ST_FULL   = 3'd1,
        ST_RAN    = 3'd2,
        ST_IDLE   = 3'd3,
        ST_PAST   = 3'd4
    } status_t;

    typedef struct packed {
        logic               func;
        logic [IDENT_W-1:0] task_ident;
        logic [PRI_W-1:0]   task_priority;
        logic [PER_W-1:0]   task_period;
        logic [REL_W-1:0]   first_release;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [IDENT_W-1:0] ran_ident;
        logic [TICK_W-1:0]  tick_time;
    } rsp_t;

endpackage

// ===== rtl/core/fppt_table.sv =====
// Task table memory: one write port, one read port, registered read data.
module fppt_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 72
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/fppt_regs.sv =====
// Configuration register block: tick_limit behind an APB-style port.
module fppt_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fppt_pkg::ADDR_W-1:0]    paddr,
    input  logic [fppt_pkg::DATA_W-1:0]    pwdata,
    output logic [fppt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [fppt_pkg::DATA_W-1:0]    tick_limit
);

    import fppt_pkg::*;

    logic [DATA_W-1:0] limit_reg;
    logic [DATA_W-1:0] limit_next;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_TICK_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            limit_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= TICK_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata     = hit ? limit_reg : '0;
    assign tick_limit = limit_reg;

endmodule

// ===== rtl/core/fixed_priority_periodic_task_picker_unit.sv =====
// Top level of the fixed-priority periodic task picker: sequencer around the task table.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   req     | in        | req_valid / req_stall | fppt_pkg::req_t (load or tick)
//   rsp     | out       | rsp_valid / rsp_stall | fppt_pkg::rsp_t (one per item)
//   apb     | in        | psel, penable, pready | tick_limit at byte address 0
//
// A load, or a tick past the limit or with an empty table, goes straight to the finish
// state; else a tick reads each stored task once (one table read per slot on the single
// read port), and when the chosen run-once task sits at slot k below the last slot,
// the entries behind it are moved down one slot each.
// Reset clears the slot count, the current time and tick_limit (all ones); the table
// contents need no clearing since only slots below the count are read.
// req_stall is high while an item is in work; a stalled rsp holds the finished item
// in its wait state, while the output register alone lets the next item in.
module fixed_priority_periodic_task_picker_unit #(
    parameter int TASK_SLOTS = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  fppt_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output fppt_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fppt_pkg::ADDR_W-1:0] paddr,
    input  logic [fppt_pkg::DATA_W-1:0] pwdata,
    output logic [fppt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    import fppt_pkg::*;

    localparam int IDX_W  = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int ENT_W  = IDENT_W + PRI_W + PER_W + TIME_BITS;
    localparam int PER_LO = TIME_BITS;
    localparam int PRI_LO = TIME_BITS + PER_W;
    localparam int ID_LO  = TIME_BITS + PER_W + PRI_W;
    localparam int SUM_W  = ((TIME_BITS > PER_W) ? TIME_BITS : PER_W) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // Control state
    state_t               state_reg,  state_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [TIME_BITS-1:0] now_reg,    now_next;
    logic [IDX_W-1:0]     ptr_reg,    ptr_next;
    logic                 found_reg,  found_next;
    logic                 rsp_valid_reg;

    // Payload state
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [IDENT_W-1:0]   best_id_reg,  best_id_next;
    logic [PRI_W-1:0]     best_pri_reg, best_pri_next;
    logic [PER_W-1:0]     best_per_reg, best_per_next;
    logic [TIME_BITS-1:0] best_rel_reg, best_rel_next;
    rsp_t                 res_reg,      res_next;
    rsp_t                 rsp_reg;

    // Table port
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENT_W-1:0]     rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     wr_data;

    // Derived values
    logic [DATA_W-1:0]    tick_limit;
    logic [63:0]          limit64;
    logic [63:0]          release64;
    logic [63:0]          now64;
    logic [TIME_BITS-1:0] limit_t;
    logic [TIME_BITS-1:0] load_rel;
    logic [TICK_W-1:0]    tick_now;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     ptr_inc1;
    logic [IDX_W-1:0]     ptr_inc2;
    logic                 table_full;
    logic                 out_room;
    logic [SUM_W-1:0]     rel_sum;
    logic [TIME_BITS-1:0] rel_sat;
    logic [TIME_BITS-1:0] rd_rel;
    logic [PRI_W-1:0]     rd_pri;
    logic                 take;

    fppt_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tick_limit (tick_limit)
    );

    fppt_table #(
        .DEPTH (TASK_SLOTS),
        .WIDTH (ENT_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Fold the 32-bit register and field into the time width; report the low 32 bits
    assign limit64   = 64'(tick_limit);
    assign release64 = 64'(req.first_release);
    assign now64     = 64'(now_reg);
    assign limit_t   = limit64[TIME_BITS-1:0];
    assign load_rel  = release64[TIME_BITS-1:0];
    assign tick_now  = now64[TICK_W-1:0];

    assign last_idx   = IDX_W'(count_reg - 1'b1);
    assign ptr_inc1   = ptr_reg + 1'b1;
    assign ptr_inc2   = ptr_inc1 + 1'b1;
    assign table_full = (count_reg == CNT_W'(TASK_SLOTS));
    assign out_room   = !rsp_valid_reg || !rsp_stall;

    // Release plus period, saturating at the top of the time range
    assign rel_sum = SUM_W'(best_rel_reg) + SUM_W'(best_per_reg);
    assign rel_sat = (rel_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : rel_sum[TIME_BITS-1:0];

    // Scan compare on the entry coming out of the table; strict less-than keeps
    // the earliest-loaded task on a priority tie
    assign rd_rel = rd_data[TIME_BITS-1:0];
    assign rd_pri = rd_data[PRI_LO +: PRI_W];
    assign take   = (rd_rel <= now_reg) && (!found_reg || (rd_pri < best_pri_reg));

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        ptr_next      = ptr_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_id_next  = best_id_reg;
        best_pri_next = best_pri_reg;
        best_per_next = best_per_reg;
        best_rel_next = best_rel_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_inc1;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = {req.task_ident, req.task_priority, req.task_period, load_rel};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.ran_ident = '0;
                    res_next.tick_time = tick_now;
                    state_next         = S_FINISH;
                    if (req.func == FUNC_LOAD)
                    begin
                        // Append at the end of the table, or refuse when full
                        if (table_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.status = ST_LOADED;
                            wr_en           = 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    else if (now_reg >= limit_t)
                    begin
                        res_next.status = ST_PAST;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = ST_IDLE;
                        now_next        = now_reg + 1'b1;
                    end
                    else
                    begin
                        // Start the scan at slot zero
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        ptr_next   = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = ptr_reg;
                    best_id_next  = rd_data[ID_LO +: IDENT_W];
                    best_pri_next = rd_pri;
                    best_per_next = rd_data[PER_LO +: PER_W];
                    best_rel_next = rd_rel;
                end
                if (ptr_reg == last_idx)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_inc1;
                    ptr_next = ptr_inc1;
                end
            end

            S_DECIDE:
            begin
                res_next.tick_time = tick_now;
                now_next           = now_reg + 1'b1;
                state_next         = S_FINISH;
                if (!found_reg)
                begin
                    res_next.status    = ST_IDLE;
                    res_next.ran_ident = '0;
                end
                else
                begin
                    res_next.status    = ST_RAN;
                    res_next.ran_ident = best_id_reg;
                    if (best_per_reg != '0)
                    begin
                        // Reschedule in place
                        wr_en   = 1'b1;
                        wr_addr = best_idx_reg;
                        wr_data = {best_id_reg, best_pri_reg, best_per_reg, rel_sat};
                    end
                    else if (best_idx_reg == last_idx)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        // Drop the task: pull the tail down one slot at a time
                        rd_en      = 1'b1;
                        rd_addr    = best_idx_reg + 1'b1;
                        ptr_next   = best_idx_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
                if (ptr_inc1 == last_idx)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_inc2;
                    ptr_next = ptr_inc1;
                end
            end

            S_FINISH:
            begin
                // Hold the item until the output register frees up
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            ptr_reg   <= ptr_next;
            found_reg <= found_next;
            if ((state_reg == S_FINISH) && out_room)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_id_reg  <= best_id_next;
        best_pri_reg <= best_pri_next;
        best_per_reg <= best_per_next;
        best_rel_reg <= best_rel_next;
        res_reg      <= res_next;
        if ((state_reg == S_FINISH) && out_room)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TASK_SLOTS))
        else $error("slot count exceeds table depth");

    a_time_step : assert property (@(posedge clk) disable iff (!rst_n)
        (now_reg != $past(now_reg)) |-> (now_reg == $past(now_reg) + 1'b1))
        else $error("current time moved by other than one");

    a_port_split : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("table read and write hit the same slot");

    a_best_in_table : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && found_reg) |-> (CNT_W'(best_idx_reg) < count_reg))
        else $error("chosen slot lies beyond the table fill");

endmodule
